### hw/rtl/tcw_pkg.sv
// Shared types, constants and helpers for the text console writer.
// No dependencies; imported by every module of the block.
`default_nettype none

package tcw_pkg;

    localparam int ROWS       = 25;
    localparam int COLUMNS    = 80;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    localparam int ROW_W     = $clog2(ROWS);
    localparam int ROW_SUM_W = ROW_W + 1;
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int ADDR_W    = $clog2(CELL_COUNT);

    localparam int REQ_W        = 2;
    localparam int CHAR_W       = 8;
    localparam int ATTR_W       = 8;
    localparam int COLOR_W      = 4;
    localparam int CELL_W       = 16;
    localparam int RD_ROW_W     = 5;
    localparam int RD_COL_W     = 7;
    localparam int ROW_FIELD_W  = 5;
    localparam int COL_FIELD_W  = 7;
    localparam int S_TDATA_W    = 24;
    localparam int S_TUSER_W    = 2;
    localparam int M_TDATA_W    = 32;
    localparam int CFG_IDX_W    = 1;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = QPTR_W + 1;

    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FORE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK = 1'b1;

    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'h20;
    localparam logic [CELL_W-1:0]  RESET_CELL   = 16'h0F20;
    localparam logic [COLOR_W-1:0] FORE_RESET   = 4'hF;
    localparam logic [COLOR_W-1:0] BACK_RESET   = 4'h0;

    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_WRITE,
        CMD_READ,
        CMD_CLEAR
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t                  op;
        logic                     scroll;
        logic [ADDR_W-1:0]        addr;
        logic [ADDR_W-1:0]        row_addr;
        logic [ATTR_W-1:0]        attr;
        logic [CHAR_W-1:0]        char_code;
        logic [ROW_FIELD_W-1:0]   cursor_row;
        logic [COL_FIELD_W-1:0]   cursor_col;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SWEEP,
        ST_READ,
        ST_EMIT
    } back_state_t;

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [ROW_W-1:0] row,
        input logic [ROW_W-1:0] base,
        input logic [COL_W-1:0] col
    );
        logic [ROW_SUM_W-1:0] sum;
        sum = {1'b0, row} + {1'b0, base};
        if (sum >= ROW_SUM_W'(ROWS))
        begin
            sum = sum - ROW_SUM_W'(ROWS);
        end
        return ADDR_W'(sum[ROW_W-1:0]) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/tcw_front.sv
// Front end: accepts requests and configuration, tracks cursor and scroll base.
// Depends on tcw_pkg; feeds commands to tcw_queue.
`default_nettype none

module tcw_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [tcw_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  wire logic [tcw_pkg::S_TUSER_W-1:0] s_axis_tuser,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tcw_pkg::COLOR_W-1:0]   cfg_data,
    input  wire logic                          init_done,
    input  wire logic                          q_ready,
    output logic                               q_push,
    output tcw_pkg::cmd_t                      q_cmd
);
    import tcw_pkg::*;

    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   base_reg, base_next;
    logic [COLOR_W-1:0] fore_reg, back_reg;

    logic [REQ_W-1:0]    req;
    logic [CHAR_W-1:0]   ch;
    logic [RD_ROW_W-1:0] rd_row;
    logic [RD_COL_W-1:0] rd_col;
    logic                line_feed;

    assign req    = s_axis_tuser;
    assign ch     = s_axis_tdata[7:0];
    assign rd_row = s_axis_tdata[12:8];
    assign rd_col = s_axis_tdata[19:13];

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = q_ready && init_done;
    assign q_push        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        base_next = base_reg;
        line_feed = 1'b0;

        q_cmd            = '0;
        q_cmd.op         = CMD_NOP;
        q_cmd.addr       = cell_addr(row_reg, base_reg, col_reg);
        q_cmd.row_addr   = ADDR_W'(base_reg) * ADDR_W'(COLUMNS);
        q_cmd.attr       = {back_reg, fore_reg};
        q_cmd.char_code  = ch;

        case (req)
            REQ_PUT:
            begin
                if (ch != NEWLINE_CODE)
                begin
                    q_cmd.op = CMD_WRITE;
                    if (col_reg == COL_W'(COLUMNS - 1))
                    begin
                        line_feed = 1'b1;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
                else
                begin
                    line_feed = 1'b1;
                end
            end
            REQ_CLEAR:
            begin
                q_cmd.op  = CMD_CLEAR;
                row_next  = '0;
                col_next  = '0;
                base_next = '0;
            end
            REQ_READ:
            begin
                if (32'(rd_row) < 32'(ROWS) && 32'(rd_col) < 32'(COLUMNS))
                begin
                    q_cmd.op   = CMD_READ;
                    q_cmd.addr = cell_addr(ROW_W'(rd_row), base_reg, COL_W'(rd_col));
                end
            end
            default:
            begin
                q_cmd.op = CMD_NOP;
            end
        endcase

        if (line_feed)
        begin
            col_next = '0;
            if (row_reg == ROW_W'(ROWS - 1))
            begin
                q_cmd.scroll = 1'b1;
                if (base_reg == ROW_W'(ROWS - 1))
                begin
                    base_next = '0;
                end
                else
                begin
                    base_next = base_reg + 1'b1;
                end
            end
            else
            begin
                row_next = row_reg + 1'b1;
            end
        end

        q_cmd.cursor_row = ROW_FIELD_W'(row_next);
        q_cmd.cursor_col = COL_FIELD_W'(col_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            base_reg <= '0;
        end
        else if (q_push)
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            base_reg <= base_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fore_reg <= FORE_RESET;
            back_reg <= BACK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FORE: fore_reg <= cfg_data;
                CFG_BACK: back_reg <= cfg_data;
                default:  fore_reg <= fore_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/tcw_queue.sv
// Short command queue between the front end and the back end.
// Depends on tcw_pkg for the command type.
`default_nettype none

module tcw_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire tcw_pkg::cmd_t push_cmd,
    output logic               ready,
    input  wire logic          pop,
    output logic               valid,
    output tcw_pkg::cmd_t      head
);
    import tcw_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign valid = count_reg != '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/tcw_back.sv
// Back end: owns the screen memory, runs writes, reads and blanking sweeps.
// Depends on tcw_pkg; takes commands from tcw_queue and drives the result stream.
`default_nettype none

module tcw_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire tcw_pkg::cmd_t                 q_cmd,
    output logic                               q_pop,
    output logic                               init_done,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [tcw_pkg::M_TDATA_W-1:0]      m_axis_tdata
);
    import tcw_pkg::*;

    back_state_t state_reg, state_next;

    logic [CELL_W-1:0] mem [CELL_COUNT];
    logic [CELL_W-1:0] rd_data_reg;

    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [ADDR_W-1:0] sweep_end_reg, sweep_end_next;

    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic              out_free;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic              load;
    logic [CELL_W-1:0] load_cell;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign init_done     = state_reg != ST_INIT;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_end_next  = sweep_end_reg;
        wr_en           = 1'b0;
        wr_addr         = sweep_addr_reg;
        wr_data         = {q_cmd.attr, BLANK_CODE};
        rd_en           = 1'b0;
        load            = 1'b0;
        load_cell       = '0;
        q_pop           = 1'b0;

        case (state_reg)
            ST_INIT:
            begin
                wr_en   = 1'b1;
                wr_data = RESET_CELL;
                if (sweep_addr_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    sweep_addr_next = '0;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_cmd.op)
                        CMD_CLEAR:
                        begin
                            sweep_addr_next = '0;
                            sweep_end_next  = ADDR_W'(CELL_COUNT - 1);
                            state_next      = ST_SWEEP;
                        end
                        CMD_READ:
                        begin
                            if (out_free)
                            begin
                                rd_en      = 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        CMD_WRITE:
                        begin
                            if (q_cmd.scroll || out_free)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = q_cmd.addr;
                                wr_data = {q_cmd.attr, q_cmd.char_code};
                            end
                            if (q_cmd.scroll)
                            begin
                                sweep_addr_next = q_cmd.row_addr;
                                sweep_end_next  = q_cmd.row_addr + ADDR_W'(COLUMNS - 1);
                                state_next      = ST_SWEEP;
                            end
                            else if (out_free)
                            begin
                                load  = 1'b1;
                                q_pop = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (q_cmd.scroll)
                            begin
                                sweep_addr_next = q_cmd.row_addr;
                                sweep_end_next  = q_cmd.row_addr + ADDR_W'(COLUMNS - 1);
                                state_next      = ST_SWEEP;
                            end
                            else if (out_free)
                            begin
                                load  = 1'b1;
                                q_pop = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                wr_en = 1'b1;
                if (sweep_addr_reg == sweep_end_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + 1'b1;
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    load_cell  = rd_data_reg;
                    q_pop      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    q_pop      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = M_TDATA_W'({q_cmd.scroll, load_cell,
                                         q_cmd.cursor_col, q_cmd.cursor_row});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            sweep_addr_reg <= '0;
            sweep_end_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_end_reg  <= sweep_end_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[q_cmd.addr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/text_console_writer_unit.sv
// Top level of the text console writer: front end, command queue, back end.
// Depends on tcw_pkg, tcw_front, tcw_queue and tcw_back.
//
// An 80x25 text screen of 16-bit cells (character low byte, attribute
// back<<4 | fore high byte) with a cursor. Each request yields one result
// transaction holding the cursor after the request, the cell read (read
// requests only) and a scroll flag. After reset the block fills every cell
// of the screen with white-on-black blanks and takes no request meanwhile.
// The screen memory has one write and one read port and the back end
// handles one cell per cycle: a put or newline without scrolling and an
// out-of-range read are answered from ST_IDLE, an in-range read passes
// through ST_READ, a scroll blanks the new bottom row in ST_SWEEP before
// ST_EMIT (rows are kept in a circular order, so only that row is blanked), and
// a clear blanks every cell in ST_SWEEP before ST_EMIT. A 2-entry queue lets
// the front end accept requests while the back end works or the result waits.
`default_nettype none

module text_console_writer_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // char_code[7:0], read_row[12:8], read_col[19:13], zero fill
    input  wire logic [tcw_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // req_type[1:0]
    input  wire logic [tcw_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // cursor_row[4:0], cursor_col[11:5], cell_value[27:12], scrolled[28], zero fill
    output logic [tcw_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tcw_pkg::COLOR_W-1:0]   cfg_data
);
    import tcw_pkg::*;

    logic init_done;
    logic q_ready;
    logic q_push;
    cmd_t q_push_cmd;
    logic q_pop;
    logic q_valid;
    cmd_t q_head;

    tcw_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .init_done     (init_done),
        .q_ready       (q_ready),
        .q_push        (q_push),
        .q_cmd         (q_push_cmd)
    );

    tcw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .ready    (q_ready),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    tcw_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_cmd         (q_head),
        .q_pop         (q_pop),
        .init_done     (init_done),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

### test/text_console_writer_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for text_console_writer_unit: directed table, then random requests.
// Depends on tcw_pkg and the block's RTL; results are checked against a built-in screen model.

module text_console_writer_unit_tb;

    import tcw_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [ROW_FIELD_W-1:0] row;
        logic [COL_FIELD_W-1:0] col;
        logic [CELL_W-1:0]      cell_val;
        logic                   scrolled;
    } console_result_t;

    typedef struct packed {
        logic [REQ_W-1:0]    req;
        logic [CHAR_W-1:0]   ch;
        logic [RD_ROW_W-1:0] rr;
        logic [RD_COL_W-1:0] rc;
        logic                typed;
        console_result_t     want;
    } console_req_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [S_TUSER_W-1:0]   s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [COLOR_W-1:0]     cfg_data = '0;

    logic [CELL_W-1:0]      screen_model [CELL_COUNT];
    logic [ROW_FIELD_W-1:0] cur_r = '0;
    logic [COL_FIELD_W-1:0] cur_c = '0;
    logic [COLOR_W-1:0]     fore_m = FORE_RESET;
    logic [COLOR_W-1:0]     back_m = BACK_RESET;

    console_result_t pending_console_states [$];
    bit              calm = 1'b0;
    int              fault_count = 0;
    int              n_put = 0;
    int              n_read = 0;
    int              n_clear = 0;
    int              n_unused = 0;
    int              n_scroll = 0;
    int              n_wrap = 0;

    console_req_t directed_reqs [0:21] = '{
        '{REQ_READ,   8'h00,  5'd0,   7'd0, 1'b1, '{5'd0, 7'd0, 16'h0F20, 1'b0}},
        '{REQ_READ,   8'h00, 5'd24,  7'd79, 1'b1, '{5'd0, 7'd0, 16'h0F20, 1'b0}},
        '{REQ_READ,   8'hFF, 5'd31, 7'd127, 1'b1, '{5'd0, 7'd0, 16'h0000, 1'b0}},
        '{REQ_READ,   8'h00, 5'd25,   7'd5, 1'b1, '{5'd0, 7'd0, 16'h0000, 1'b0}},
        '{REQ_READ,   8'h00,  5'd3,  7'd80, 1'b1, '{5'd0, 7'd0, 16'h0000, 1'b0}},
        '{REQ_UNUSED, 8'h41,  5'd2,   7'd3, 1'b1, '{5'd0, 7'd0, 16'h0000, 1'b0}},
        '{REQ_PUT,    8'h41,  5'd0,   7'd0, 1'b1, '{5'd0, 7'd1, 16'h0000, 1'b0}},
        '{REQ_PUT,    8'hFF, 5'd31, 7'd127, 1'b1, '{5'd0, 7'd2, 16'h0000, 1'b0}},
        '{REQ_PUT,    8'h00,  5'd0,   7'd0, 1'b1, '{5'd0, 7'd3, 16'h0000, 1'b0}},
        '{REQ_READ,   8'h00,  5'd0,   7'd0, 1'b1, '{5'd0, 7'd3, 16'h0F41, 1'b0}},
        '{REQ_READ,   8'h00,  5'd0,   7'd1, 1'b1, '{5'd0, 7'd3, 16'h0FFF, 1'b0}},
        '{REQ_READ,   8'h00,  5'd0,   7'd2, 1'b1, '{5'd0, 7'd3, 16'h0F00, 1'b0}},
        '{REQ_PUT,    8'h0A,  5'd0,   7'd0, 1'b1, '{5'd1, 7'd0, 16'h0000, 1'b0}},
        '{REQ_PUT,    8'h7E,  5'd0,   7'd0, 1'b1, '{5'd1, 7'd1, 16'h0000, 1'b0}},
        '{REQ_PUT,    8'h0A, 5'd31, 7'd127, 1'b0, '0},
        '{REQ_PUT,    8'h80,  5'd0,   7'd0, 1'b0, '0},
        '{REQ_READ,   8'h00,  5'd1,   7'd0, 1'b0, '0},
        '{REQ_CLEAR,  8'hFF, 5'd31, 7'd127, 1'b1, '{5'd0, 7'd0, 16'h0000, 1'b0}},
        '{REQ_READ,   8'h00,  5'd1,   7'd0, 1'b1, '{5'd0, 7'd0, 16'h0F20, 1'b0}},
        '{REQ_UNUSED, 8'hFF, 5'd31, 7'd127, 1'b1, '{5'd0, 7'd0, 16'h0000, 1'b0}},
        '{REQ_PUT,    8'h0A,  5'd0,   7'd0, 1'b0, '0},
        '{REQ_READ,   8'h00,  5'd2,   7'd0, 1'b0, '0}
    };

    text_console_writer_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < CELL_COUNT; i++)
        begin
            screen_model[i] = RESET_CELL;
        end
    end

    function automatic logic [CELL_W-1:0] colored_cell(input logic [CHAR_W-1:0] ch);
        return {back_m, fore_m, ch};
    endfunction

    task automatic feed_line(output logic rolled);
        rolled = 1'b0;
        cur_c = '0;
        if (int'(cur_r) + 1 >= ROWS)
        begin
            cur_r = ROW_FIELD_W'(ROWS - 1);
            for (int i = 0; i < CELL_COUNT; i++)
            begin
                screen_model[i] = (i + COLUMNS < CELL_COUNT) ? screen_model[i + COLUMNS]
                                                             : colored_cell(BLANK_CODE);
            end
            rolled = 1'b1;
        end
        else
        begin
            cur_r = cur_r + 1'b1;
        end
    endtask

    task automatic console_apply(input console_req_t r, output console_result_t res);
        logic rolled;
        int   idx;
        rolled = 1'b0;
        res = '0;
        case (r.req)
            REQ_PUT:
            begin
                if (r.ch == NEWLINE_CODE)
                begin
                    feed_line(rolled);
                end
                else
                begin
                    idx = int'(cur_r) * COLUMNS + int'(cur_c);
                    if (idx < CELL_COUNT)
                    begin
                        screen_model[idx] = colored_cell(r.ch);
                    end
                    cur_c = cur_c + 1'b1;
                    if (int'(cur_c) >= COLUMNS)
                    begin
                        n_wrap++;
                        feed_line(rolled);
                    end
                end
            end
            REQ_CLEAR:
            begin
                for (int i = 0; i < CELL_COUNT; i++)
                begin
                    screen_model[i] = colored_cell(BLANK_CODE);
                end
                cur_r = '0;
                cur_c = '0;
            end
            REQ_READ:
            begin
                if (int'(r.rr) < ROWS && int'(r.rc) < COLUMNS)
                begin
                    res.cell_val = screen_model[int'(r.rr) * COLUMNS + int'(r.rc)];
                end
            end
            default:
            begin
            end
        endcase
        res.row = cur_r;
        res.col = cur_c;
        res.scrolled = rolled;
    endtask

    task automatic flag_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
        begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    task automatic send_request(input console_req_t r);
        console_result_t pred;
        while (!calm && $urandom_range(0, 99) < 17)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'({r.rc, r.rr, r.ch});
        s_axis_tuser  <= r.req;
        do @(posedge clk); while (!s_axis_tready);
        console_apply(r, pred);
        pending_console_states.push_back(r.typed ? r.want : pred);
        case (r.req)
            REQ_PUT:   n_put++;
            REQ_READ:  n_read++;
            REQ_CLEAR: n_clear++;
            default:   n_unused++;
        endcase
        if (pred.scrolled)
        begin
            n_scroll++;
        end
    endtask

    task automatic wait_drained;
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_console_states.size() != 0);
    endtask

    task automatic set_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_FORE;
        cfg_data  <= fg;
        do @(posedge clk); while (!cfg_ready);
        fore_m = fg;
        cfg_index <= CFG_BACK;
        cfg_data  <= bg;
        do @(posedge clk); while (!cfg_ready);
        back_m = bg;
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 17);
    end

    always @(posedge clk)
    begin : check_results
        console_result_t got;
        console_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.row      = m_axis_tdata[4:0];
            got.col      = m_axis_tdata[11:5];
            got.cell_val = m_axis_tdata[27:12];
            got.scrolled = m_axis_tdata[28];
            if (pending_console_states.size() == 0)
            begin
                flag_fault($sformatf("unexpected result transaction %h", m_axis_tdata));
            end
            else
            begin
                want = pending_console_states.pop_front();
                if (got.row != want.row || got.col != want.col
                    || got.cell_val != want.cell_val || got.scrolled != want.scrolled)
                begin
                    flag_fault($sformatf(
                        "mismatch: want row %0d col %0d cell %h scr %0d, got row %0d col %0d cell %h scr %0d",
                        want.row, want.col, want.cell_val, want.scrolled,
                        got.row, got.col, got.cell_val, got.scrolled));
                end
            end
        end
    end

    initial
    begin : stimulus
        console_req_t    r;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        int              nl_pct;
        int              pick;
        int              clears;
        clears = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        set_colors(FORE_RESET, BACK_RESET);
        foreach (directed_reqs[k])
        begin
            send_request(directed_reqs[k]);
        end
        wait_drained();

        for (int p = 0; p < 5; p++)
        begin
            calm = 1'b0;
            case (p)
                0: begin fg = 4'h0; bg = 4'hF; nl_pct = 20; end
                1: begin fg = 4'hA; bg = 4'h5; nl_pct = 2; calm = 1'b1; end
                2: begin fg = 4'hF; bg = 4'hF; nl_pct = 20; end
                3: begin fg = 4'h0; bg = 4'h0; nl_pct = 3; end
                default: begin fg = 4'h3; bg = 4'hC; nl_pct = 12; end
            endcase
            set_colors(fg, bg);
            for (int n = 0; n < 320; n++)
            begin
                if (n == 160)
                begin
                    wait_drained();
                end
                pick  = $urandom_range(0, 999);
                r     = '0;
                r.ch  = CHAR_W'($urandom_range(0, 255));
                r.rr  = RD_ROW_W'($urandom_range(0, 31));
                r.rc  = RD_COL_W'($urandom_range(0, 127));
                if (pick < 3 && clears < 12)
                begin
                    r.req = REQ_CLEAR;
                    clears++;
                end
                else if (pick < 18)
                begin
                    r.req = REQ_UNUSED;
                end
                else if (pick < 220)
                begin
                    r.req = REQ_READ;
                    pick = $urandom_range(0, 99);
                    if (pick < 40)
                    begin
                        r.rr = cur_r - RD_ROW_W'($urandom_range(0, (cur_r > 2) ? 2 : cur_r));
                        r.rc = RD_COL_W'($urandom_range(0, COLUMNS - 1));
                    end
                    else if (pick < 85)
                    begin
                        r.rr = RD_ROW_W'($urandom_range(0, ROWS - 1));
                        r.rc = RD_COL_W'($urandom_range(0, COLUMNS - 1));
                    end
                end
                else
                begin
                    r.req = REQ_PUT;
                    if ($urandom_range(0, 99) < nl_pct)
                    begin
                        r.ch = NEWLINE_CODE;
                    end
                end
                send_request(r);
            end
            wait_drained();
        end

        repeat (64) @(posedge clk);
        $display("covered %0d puts, %0d reads, %0d clears, %0d unused requests",
                 n_put, n_read, n_clear, n_unused);
        $display("screen scrolled %0d times, %0d row-end wraps, 6 color settings",
                 n_scroll, n_wrap);
        if (fault_count == 0 && pending_console_states.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_front.sv
hw/rtl/tcw_queue.sv
hw/rtl/tcw_back.sv
hw/rtl/text_console_writer_unit.sv
test/text_console_writer_unit_tb.sv
